>>> hdl/papa_pkg.sv
// Shared types and constants for the positional pan and attenuation pipeline.
`default_nettype none
package papa_pkg;

  // Number of entries in the arctangent table.
  localparam int AtanLen = 24;

  // Number of result bits of the distance root.
  localparam int SqSteps = 29;

  // Number of quotient bits of the attenuation divider.
  localparam int DivSteps = 8;

  // Arctangent of 2^-i in degrees, Q.16, rounded.
  localparam logic [22:0] ATAN_Q16 [0:AtanLen-1] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  // Square root cell data: remaining radicand and partial root.
  typedef struct packed {
    logic [57:0] v;
    logic [58:0] r;
  } sq_t;

  // Rotation cell data: vector and accumulated angle (two's complement).
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [25:0] z;
  } cd_t;

  // Divider cell data: partial remainder, divisor and quotient.
  typedef struct packed {
    logic [32:0] rem;
    logic [24:0] d;
    logic [7:0]  q;
  } dv_t;

  // Per-item side information that travels down the pipeline from stage 2 to the last stage.
  typedef struct packed {
    logic [7:0]  vol;
    logic        centered;
    logic        sel_close;
    logic        act;
    logic        sat;
    logic [20:0] dx;
  } side_t;

endpackage
`default_nettype wire

>>> hdl/papa_sqrt_cell.sv
// One digit step of the pipelined integer square root.
`default_nettype none
module papa_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  papa_pkg::sq_t      cell_in,
  output papa_pkg::sq_t      cell_out
);

  localparam logic [58:0] Bit = 59'(1) << SHIFT;

  papa_pkg::sq_t cell_r;
  papa_pkg::sq_t cell_nxt;
  logic [58:0]   trial;

  // Subtract the trial value when it fits, and shift the partial root.
  always_comb begin
    trial    = cell_in.r + Bit;
    cell_nxt = cell_in;
    if ({1'b0, cell_in.v} >= trial) begin
      cell_nxt.v = cell_in.v - trial[57:0];
      cell_nxt.r = (cell_in.r >> 1) + Bit;
    end else begin
      cell_nxt.r = cell_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

>>> hdl/papa_cordic_cell.sv
// One vectoring rotation of the pipelined arctangent.
`default_nettype none
module papa_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  papa_pkg::cd_t      cell_in,
  output papa_pkg::cd_t      cell_out
);

  localparam logic [25:0] Ang = {3'b000, papa_pkg::ATAN_Q16[STEP]};

  papa_pkg::cd_t cell_r;
  papa_pkg::cd_t cell_nxt;
  logic [31:0]   xs;
  logic [31:0]   ys;

  // Arithmetic shift that truncates toward zero.
  function automatic logic [31:0] shr_tz(input logic [31:0] v);
    logic [31:0] m;
    begin
      m = v[31] ? (32'd0 - v) : v;
      m = m >> STEP;
      return v[31] ? (32'd0 - m) : m;
    end
  endfunction

  // Rotate toward the x axis, steering by the sign of y.
  always_comb begin
    xs       = shr_tz(cell_in.x);
    ys       = shr_tz(cell_in.y);
    cell_nxt = cell_in;
    if (!cell_in.y[31]) begin
      cell_nxt.x = cell_in.x + ys;
      cell_nxt.y = cell_in.y - xs;
      cell_nxt.z = cell_in.z + Ang;
    end else begin
      cell_nxt.x = cell_in.x - ys;
      cell_nxt.y = cell_in.y + xs;
      cell_nxt.z = cell_in.z - Ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

>>> hdl/papa_div_cell.sv
// One quotient bit of the restoring attenuation divider.
`default_nettype none
module papa_div_cell #(
  parameter int BITPOS = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  papa_pkg::dv_t      cell_in,
  output papa_pkg::dv_t      cell_out
);

  localparam logic [7:0] QBit = 8'(1) << BITPOS;

  papa_pkg::dv_t cell_r;
  papa_pkg::dv_t cell_nxt;
  logic [32:0]   dsh;

  // Subtract the shifted divisor when it fits and set this quotient bit.
  always_comb begin
    dsh      = 33'(cell_in.d) << BITPOS;
    cell_nxt = cell_in;
    if (cell_in.rem >= dsh) begin
      cell_nxt.rem = cell_in.rem - dsh;
      cell_nxt.q   = cell_in.q | QBit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

>>> hdl/positional_audio_pan_attenuate_core.sv
// Top level: volume, distance attenuation and pan angle pipeline for sound sources.
// Throughput: one item per cycle unless halted; the 29-cell square root chain sets
// the depth. The pipeline halts only while its last stage and the output register
// are both full and the output is stalled. Synchronous active-low reset clears all
// valid flags and returns the configuration registers to their reset values.
`default_nettype none
module positional_audio_pan_attenuate_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_placement_mode,
  input  wire logic        in_has_position,
  input  wire logic [19:0] in_source_x,
  input  wire logic [19:0] in_source_y,
  input  wire logic [19:0] in_listener_x,
  input  wire logic [19:0] in_listener_y,
  input  wire logic [15:0] in_source_gain_q14,
  input  wire logic [15:0] in_close_factor_q14,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_channel_volume,
  output logic             out_centered,
  output logic [8:0]       out_pan_degrees,
  output logic [7:0]       out_distance_attenuation,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Register indexes and placement codes.
  localparam logic [2:0] RegSetback      = 3'd0;
  localparam logic [2:0] RegPlacedSil    = 3'd1;
  localparam logic [2:0] RegCloseSil     = 3'd2;
  localparam logic [2:0] RegPlacedLevel  = 3'd3;
  localparam logic [2:0] RegCloseLevel   = 3'd4;
  localparam logic [1:0] ModePlaced      = 2'd1;
  localparam logic [1:0] ModeClose       = 2'd2;

  // Stage numbering.
  localparam int SqN     = papa_pkg::SqSteps;
  localparam int DvN     = papa_pkg::DivSteps;
  localparam int SqInSt  = 3;
  localparam int NumSt   = SqInSt + SqN + 1;
  localparam int SatSt   = NumSt + 1;
  localparam int Last    = SatSt + DvN;
  localparam int CdInSt  = Last - CORDIC_STEPS;

  // Configuration registers.
  logic [15:0] setback_r;
  logic [15:0] placed_sil_r;
  logic [15:0] close_sil_r;
  logic [15:0] placed_lvl_r;
  logic [15:0] close_lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setback_r    <= 16'd0;
      placed_sil_r <= 16'd0;
      close_sil_r  <= 16'd0;
      placed_lvl_r <= 16'd16384;
      close_lvl_r  <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSetback:     setback_r    <= cfg_data;
        RegPlacedSil:   placed_sil_r <= cfg_data;
        RegCloseSil:    close_sil_r  <= cfg_data;
        RegPlacedLevel: placed_lvl_r <= cfg_data;
        RegCloseLevel:  close_lvl_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold only when the last stage cannot hand over.
  logic [Last:1] vld_r;
  logic          out_valid_r;
  logic          en;
  logic          take;

  assign en       = !vld_r[Last] || !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign take     = vld_r[Last] && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Last-1:1], in_valid};
    end
  end

  // Stage 1: offsets and mode level.
  logic signed [20:0] dx_c;
  logic signed [20:0] dy_c;
  logic [31:0]        lvl_close;
  logic [31:0]        lvl_c;
  logic signed [20:0] s1_dx_r;
  logic signed [20:0] s1_dy_r;
  logic [31:0]        s1_level_r;
  logic [15:0]        s1_gain_r;
  logic               s1_centered_r;
  logic               s1_close_r;

  assign dx_c      = $signed({in_source_x[19], in_source_x}) -
                     $signed({in_listener_x[19], in_listener_x});
  assign dy_c      = $signed({in_source_y[19], in_source_y}) -
                     $signed({in_listener_y[19], in_listener_y});
  assign lvl_close = {16'd0, close_lvl_r} * {16'd0, in_close_factor_q14};

  always_comb begin
    case (in_placement_mode)
      ModePlaced: lvl_c = {2'b00, placed_lvl_r, 14'd0};
      ModeClose:  lvl_c = lvl_close;
      default:    lvl_c = 32'h1000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r       <= dx_c;
      s1_dy_r       <= dy_c;
      s1_level_r    <= lvl_c;
      s1_gain_r     <= in_source_gain_q14;
      s1_centered_r <= !in_has_position ||
                       !((in_placement_mode == ModePlaced) ||
                         (in_placement_mode == ModeClose));
      s1_close_r    <= (in_placement_mode == ModeClose);
    end
  end

  // Stage 2: volume and squared distance terms.
  logic [47:0]        prod;
  logic [7:0]         vol_c;
  logic signed [41:0] dx2_full;
  logic signed [41:0] dy2_full;
  logic [31:0]        ss_c;
  logic [39:0]        dx2_r;
  logic [39:0]        dy2_r;
  logic [31:0]        ss_r;

  assign prod     = {32'd0, s1_gain_r} * {16'd0, s1_level_r};
  assign vol_c    = prod[47:42] != 6'd0 ? 8'd128 : {1'b0, prod[41:35]};
  assign dx2_full = 42'(s1_dx_r) * 42'(s1_dx_r);
  assign dy2_full = 42'(s1_dy_r) * 42'(s1_dy_r);
  assign ss_c     = {16'd0, setback_r} * {16'd0, setback_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r <= dx2_full[39:0];
      dy2_r <= dy2_full[39:0];
      ss_r  <= ss_c;
    end
  end

  // Side line carried along every stage from stage 2 to the last.
  papa_pkg::side_t side_r   [2:Last];
  papa_pkg::side_t side_nxt [2:Last];
  logic            act_c;
  logic            sat_c;

  always_comb begin
    side_nxt[2].vol       = vol_c;
    side_nxt[2].centered  = s1_centered_r;
    side_nxt[2].sel_close = s1_close_r;
    side_nxt[2].act       = 1'b0;
    side_nxt[2].sat       = 1'b0;
    side_nxt[2].dx        = s1_dx_r;
    for (int i = 3; i <= Last; i++) begin
      side_nxt[i] = side_r[i-1];
      if (i == NumSt) begin
        side_nxt[i].act = act_c;
      end
      if (i == SatSt) begin
        side_nxt[i].sat = sat_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 2; i <= Last; i++) begin
        side_r[i] <= side_nxt[i];
      end
    end
  end

  // Stage 3: radicand for the distance root, in Q.16.
  logic [41:0]   sq_sum;
  papa_pkg::sq_t sq_in_r;
  papa_pkg::sq_t sq_w [0:SqN];

  assign sq_sum = {2'b00, dx2_r} + {2'b00, dy2_r} + {10'd0, ss_r};

  always_ff @(posedge clk) begin
    if (en) begin
      sq_in_r.v <= {sq_sum, 16'd0};
      sq_in_r.r <= '0;
    end
  end

  assign sq_w[0] = sq_in_r;

  // Square root chain, one root bit per cell.
  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    papa_sqrt_cell #(
      .SHIFT(2 * (SqN - 1 - k))
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .cell_in  (sq_w[k]),
      .cell_out (sq_w[k+1])
    );
  end

  // Fall-off numerator and denominator from the distance.
  logic [28:0] d8;
  logic [15:0] silence;
  logic [15:0] sil_diff;
  logic [23:0] base;
  logic [28:0] num;
  logic [38:0] n_c;
  logic [38:0] n_r;
  logic [24:0] d_r;

  assign d8       = sq_w[SqN].r[28:0];
  assign silence  = side_r[NumSt-1].sel_close ? close_sil_r : placed_sil_r;
  assign act_c    = silence > setback_r;
  assign sil_diff = silence - setback_r;
  assign base     = {setback_r, 8'd0};
  assign num      = (d8 > {5'd0, base}) ? (d8 - {5'd0, base}) : 29'd0;
  assign n_c      = 39'(num) * 39'd510 + {15'd0, sil_diff, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_c;
      d_r <= {1'b0, sil_diff, 8'd0} << 1;
    end
  end

  // Saturation check and divider input.
  papa_pkg::dv_t dv_in_r;
  papa_pkg::dv_t dv_w [0:DvN];

  assign sat_c = n_r >= {6'd0, d_r, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      dv_in_r.rem <= n_r[32:0];
      dv_in_r.d   <= d_r;
      dv_in_r.q   <= '0;
    end
  end

  assign dv_w[0] = dv_in_r;

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < DvN; k++) begin : g_div
    papa_div_cell #(
      .BITPOS(DvN - 1 - k)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .cell_in  (dv_w[k]),
      .cell_out (dv_w[k+1])
    );
  end

  // Arctangent input, timed so its chain ends at the last stage.
  papa_pkg::cd_t cd_in_r;
  papa_pkg::cd_t cd_w [0:CORDIC_STEPS];
  logic [20:0]   cd_dx;

  assign cd_dx = side_r[CdInSt-1].dx;

  always_ff @(posedge clk) begin
    if (en) begin
      cd_in_r.x <= {8'd0, setback_r, 8'd0};
      cd_in_r.y <= {{3{cd_dx[20]}}, cd_dx, 8'd0};
      cd_in_r.z <= '0;
    end
  end

  assign cd_w[0] = cd_in_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    papa_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .cell_in  (cd_w[k]),
      .cell_out (cd_w[k+1])
    );
  end

  // Final assembly of the result fields.
  papa_pkg::side_t fin;
  logic [25:0]     zf;
  logic [25:0]     zmag;
  logic [9:0]      tmag;
  logic [8:0]      pan_c;
  logic [7:0]      att_c;

  assign fin  = side_r[Last];
  assign zf   = cd_w[CORDIC_STEPS].z;
  assign zmag = zf[25] ? (26'd0 - zf) : zf;
  assign tmag = zmag[25:16];

  always_comb begin
    if (fin.centered || (fin.dx == 21'd0)) begin
      pan_c = 9'd0;
    end else if (setback_r == 16'd0) begin
      pan_c = fin.dx[20] ? 9'd270 : 9'd90;
    end else if (zf[25] && (tmag != 10'd0)) begin
      pan_c = 9'd360 - tmag[8:0];
    end else begin
      pan_c = tmag[8:0];
    end
  end

  always_comb begin
    if (fin.centered || !fin.act) begin
      att_c = 8'd0;
    end else if (fin.sat) begin
      att_c = 8'd255;
    end else begin
      att_c = dv_w[DvN].q;
    end
  end

  // Output register; a held result blocks the pipeline only while the last stage is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_channel_volume       <= fin.vol;
      out_centered             <= fin.centered;
      out_pan_degrees          <= pan_c;
      out_distance_attenuation <= att_c;
    end
  end

  assign out_valid = out_valid_r;

  // The input is held off only while the output holds an unaccepted result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && vld_r[Last]))
    else $error("input stalled without a blocked output");

  // A finished item reaching the end with room ahead appears on the output.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("result lost at the output register");

  // A centred result carries neither pan nor attenuation.
  a_centered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_centered) |->
      ((out_pan_degrees == 9'd0) && (out_distance_attenuation == 8'd0)))
    else $error("centred result with spatial fields");

  // Volume and pan stay in their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_channel_volume <= 8'd128) && (out_pan_degrees < 9'd360)))
    else $error("result field out of range");

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the positional pan and attenuation core.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegSetback      = 3'd0;
  localparam logic [2:0] RegPlacedSilent = 3'd1;
  localparam logic [2:0] RegCloseSilent  = 3'd2;
  localparam logic [2:0] RegPlacedLevel  = 3'd3;
  localparam logic [2:0] RegCloseLevel   = 3'd4;
  localparam logic [2:0] RegSpare        = 3'd5;

  // Placement modes.
  localparam logic [1:0] ModeUnplaced = 2'd0;
  localparam logic [1:0] ModePlaced   = 2'd1;
  localparam logic [1:0] ModeClose    = 2'd2;
  localparam logic [1:0] ModeUnknown  = 2'd3;

  localparam int RotSteps   = 16;
  localparam int DrainWait  = 60;
  localparam int CycleLimit = 400000;

  // Arctangent of 2^-i in degrees, Q.16.
  localparam longint AtanDeg [0:15] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic [1:0]  mode;
    logic        positioned;
    logic [19:0] sx, sy, lx, ly;
    logic [15:0] gain, factor;
  } source_t;

  typedef struct {
    logic [7:0] vol;
    logic       centered;
    logic [8:0] pan;
    logic [7:0] att;
  } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_placement_mode = '0;
  logic in_has_position = 1'b0;
  logic [19:0] in_source_x = '0, in_source_y = '0, in_listener_x = '0, in_listener_y = '0;
  logic [15:0] in_source_gain_q14 = '0, in_close_factor_q14 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_channel_volume;
  logic out_centered;
  logic [8:0] out_pan_degrees;
  logic [7:0] out_distance_attenuation;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Local copy of the configuration registers.
  logic [15:0] setback, placed_silent, close_silent, placed_lvl, close_lvl;

  source_t source_q[$];
  mix_t    mix_q[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  bit      hold_src = 1'b1;
  bit      quiet = 1'b0;

  positional_audio_pan_attenuate_core dut (.*);

  always #10 clk = ~clk;

  // Shift right with truncation toward zero.
  function automatic longint shr_tz(longint v, int s);
    if (v < 0) return -longint'(longint'(-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [8:0] pan_angle(longint dx, longint s);
    longint x, y, z, t;
    if (dx == 0) return 9'd0;
    if (s == 0) return (dx > 0) ? 9'd90 : 9'd270;
    x = s * 256;
    y = dx * 256;
    z = 0;
    for (int i = 0; i < RotSteps; i++) begin
      t = x;
      if (y >= 0) begin
        x += shr_tz(y, i); y -= shr_tz(t, i); z += AtanDeg[i];
      end else begin
        x -= shr_tz(y, i); y += shr_tz(t, i); z -= AtanDeg[i];
      end
    end
    t = shr_tz(z, 16);
    if (t < 0) t += 360;
    return t[8:0];
  endfunction

  // Expected mixer settings for one source under the current registers.
  function automatic mix_t mix_of(source_t s);
    mix_t m;
    longint unsigned level, prod, sum, d8, den, base, num, a, silence;
    longint dx, dy, sb;
    if (s.mode == ModePlaced) level = longint'(placed_lvl) << 14;
    else if (s.mode == ModeClose) level = longint'(close_lvl) * longint'(s.factor);
    else level = 64'd1 << 28;
    prod = longint'(s.gain) * level;
    if (prod > (64'd1 << 42)) prod = 64'd1 << 42;
    prod = prod >> 35;
    if (prod > 128) prod = 128;
    m.vol = prod[7:0];
    m.centered = 1'b1;
    m.pan = '0;
    m.att = '0;
    if ((s.mode == ModePlaced || s.mode == ModeClose) && s.positioned) begin
      dx = longint'($signed(s.sx)) - longint'($signed(s.lx));
      dy = longint'($signed(s.sy)) - longint'($signed(s.ly));
      sb = longint'(setback);
      silence = (s.mode == ModeClose) ? close_silent : placed_silent;
      sum = dx * dx + dy * dy + sb * sb;
      d8 = int_root(sum << 16);
      m.centered = 1'b0;
      if (silence > sb) begin
        den = (silence - sb) << 8;
        base = sb << 8;
        num = (d8 > base) ? d8 - base : 0;
        a = (510 * num + den) / (2 * den);
        m.att = (a > 255) ? 8'd255 : a[7:0];
      end
      m.pan = pan_angle(dx, sb);
    end
    return m;
  endfunction

  // Driver: presents queued sources and predicts each one on its transfer.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mix_q.push_back(mix_of(source_q[0]));
        void'(source_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // Hold the stalled payload.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!hold_src && source_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 15) == 0) begin
          in_gap <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_placement_mode <= source_q[0].mode;
          in_has_position <= source_q[0].positioned;
          in_source_x <= source_q[0].sx;
          in_source_y <= source_q[0].sy;
          in_listener_x <= source_q[0].lx;
          in_listener_y <= source_q[0].ly;
          in_source_gain_q14 <= source_q[0].gain;
          in_close_factor_q14 <= source_q[0].factor;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stalls at random and checks every result transfer.
  always @(posedge clk) begin
    mix_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mix_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer at cycle %0d", cycles);
        end else begin
          e = mix_q.pop_front();
          if (out_channel_volume !== e.vol || out_centered !== e.centered ||
              out_pan_degrees !== e.pan || out_distance_attenuation !== e.att) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp vol %0d cen %0d pan %0d att %0d, got %0d %0d %0d %0d",
                       e.vol, e.centered, e.pan, e.att, out_channel_volume, out_centered,
                       out_pan_degrees, out_distance_attenuation);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegSetback:      setback = val;
      RegPlacedSilent: placed_silent = val;
      RegCloseSilent:  close_silent = val;
      RegPlacedLevel:  placed_lvl = val;
      RegCloseLevel:   close_lvl = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] s, logic [15:0] ps, logic [15:0] cs,
                           logic [15:0] pl, logic [15:0] cl);
    write_reg(RegSetback, s);
    write_reg(RegPlacedSilent, ps);
    write_reg(RegCloseSilent, cs);
    write_reg(RegPlacedLevel, pl);
    write_reg(RegCloseLevel, cl);
    // Indexes past the last register must leave everything untouched.
    write_reg(RegSpare + 3'($urandom_range(0, 2)), 16'($urandom));
  endtask

  function automatic source_t make_source(logic [1:0] mode, logic pos, int sx, int sy,
                                          int lx, int ly, int gain, int factor);
    source_t s;
    s.mode = mode; s.positioned = pos;
    s.sx = sx[19:0]; s.sy = sy[19:0]; s.lx = lx[19:0]; s.ly = ly[19:0];
    s.gain = gain[15:0]; s.factor = factor[15:0];
    return s;
  endfunction

  // Random source: mostly placed or close, mostly near the listener.
  function automatic source_t random_source();
    source_t s;
    int span;
    int r;
    r = $urandom_range(0, 9);
    s.mode = (r < 4) ? ModePlaced : (r < 8) ? ModeClose : 2'($urandom_range(0, 3));
    s.positioned = ($urandom_range(0, 7) != 0);
    span = ($urandom_range(0, 3) == 0) ? 524287 : ($urandom_range(0, 1) ? 20000 : 300);
    s.sx = 20'($urandom_range(0, 2 * span) - span);
    s.sy = 20'($urandom_range(0, 2 * span) - span);
    s.lx = 20'($urandom_range(0, 2 * span) - span);
    s.ly = 20'($urandom_range(0, 2 * span) - span);
    if ($urandom_range(0, 3) == 0) begin
      s.sx = 20'($urandom); s.lx = 20'($urandom);
    end
    s.gain = $urandom_range(0, 3) ? 16'($urandom_range(0, 20000)) : 16'($urandom);
    s.factor = $urandom_range(0, 3) ? 16'($urandom_range(0, 20000)) : 16'($urandom);
    return s;
  endfunction

  // Release the queued sources and wait until every result has come back.
  task automatic run_phase();
    hold_src = 1'b0;
    do @(negedge clk);
    while (source_q.size() != 0 || in_valid || mix_q.size() != 0);
    hold_src = 1'b1;
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) source_q.push_back(random_source());
    run_phase();
  endtask

  initial begin
    setback = 16'd0; placed_silent = 16'd0; close_silent = 16'd0;
    placed_lvl = 16'd16384; close_lvl = 16'd16384;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed sources under the reset registers: every mode, zero setback,
    // zero sideways offset, coordinate and gain extremes.
    source_q.push_back(make_source(ModeUnplaced, 1, 5, 5, 0, 0, 16384, 0));
    source_q.push_back(make_source(ModeUnknown, 1, 100, -7, 3, 2, 65535, 65535));
    source_q.push_back(make_source(ModePlaced, 0, 100, 7, 0, 0, 16384, 0));
    source_q.push_back(make_source(ModeClose, 0, -100, 7, 0, 0, 8192, 40000));
    source_q.push_back(make_source(ModePlaced, 1, 40, 9, 40, -9, 16384, 0));
    source_q.push_back(make_source(ModePlaced, 1, 50, 0, 0, 0, 65535, 0));
    source_q.push_back(make_source(ModeClose, 1, -50, 3, 0, 0, 0, 65535));
    source_q.push_back(make_source(ModePlaced, 1, 524287, 524287, -524288, -524288, 0, 0));
    source_q.push_back(make_source(ModeClose, 1, -524288, -524288, 524287, 524287,
                                   65535, 65535));
    source_q.push_back(make_source(ModeClose, 1, 0, 0, 0, 0, 16384, 16384));
    run_phase();

    // Full silence distances and levels, zero setback.
    load_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    source_q.push_back(make_source(ModePlaced, 1, 1, 0, 0, 0, 65535, 0));
    source_q.push_back(make_source(ModeClose, 1, -1, 65535, 0, 0, 65535, 65535));
    source_q.push_back(make_source(ModePlaced, 1, 70000, 0, 0, 0, 1, 0));
    random_phase(150);

    // Largest setback with silence not beyond it.
    load_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    source_q.push_back(make_source(ModePlaced, 1, 0, 0, 0, 0, 65535, 0));
    source_q.push_back(make_source(ModeClose, 1, 524287, 0, -524288, 0, 65535, 65535));
    random_phase(150);

    // Moderate settings where attenuation spans its whole range.
    load_regs(16'd100, 16'd5000, 16'd2000, 16'd12000, 16'd20000);
    random_phase(200);
    load_regs(16'd10, 16'd300, 16'd600, 16'd16384, 16'd4000);
    random_phase(200);

    // A few random settings, the last run without idling.
    repeat (2) begin
      load_regs(16'($urandom_range(0, 500)), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
      random_phase(150);
    end
    quiet = 1'b1;
    load_regs(16'($urandom_range(0, 50)), 16'($urandom_range(0, 30000)),
              16'($urandom_range(0, 30000)), 16'($urandom), 16'($urandom));
    random_phase(150);

    if (mismatches == 0 && mix_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
